// File: rtl/core/e2h_pkg.sv
package e2h_pkg;

  localparam int ANGLE_BITS = 32;
  localparam int TRIG_FRAC_BITS = 30;
  localparam int QF = 60;
  localparam int SIDE_W = 256;
  // sine/cosine chain covers k = 3..ANGLE_BITS, angle chain k = 3..ANGLE_BITS+1
  localparam int N_SC = ANGLE_BITS - 2;
  localparam int N_ANG = ANGLE_BITS - 1;
  localparam int N_SQ = QF + 1;

  localparam logic signed [63:0] QONE = 64'sd1 <<< QF;
  localparam logic [ANGLE_BITS-1:0] HALF_TURN = {1'b1, {(ANGLE_BITS-1){1'b0}}};
  localparam logic [ANGLE_BITS-1:0] QUARTER_TURN = {2'b01, {(ANGLE_BITS-2){1'b0}}};

  // configuration register indexes
  localparam logic [1:0] CFG_LAT_SINE = 2'd0;
  localparam logic [1:0] CFG_LAT_COSINE = 2'd1;
  localparam logic [1:0] CFG_ZEN_THRESH = 2'd2;

  typedef struct packed {
    logic                  valid;
    logic signed [63:0]    x;
    logic signed [63:0]    y;
    logic [ANGLE_BITS-1:0] acc;
    logic [SIDE_W-1:0]     side;
  } rot_pl_t;

  typedef struct packed {
    logic              valid;
    logic [65:0]       rem;
    logic [62:0]       root;
    logic [SIDE_W-1:0] side;
  } sq_pl_t;

  typedef struct packed {
    logic signed [63:0] c;
    logic signed [63:0] s;
  } tab_t;

  typedef struct packed {
    logic signed [63:0]    x;
    logic signed [63:0]    y;
    logic [ANGLE_BITS-1:0] acc;
  } fold_t;

  // partial products of a Q60 product: sign and four 32x32 magnitude parts
  typedef struct packed {
    logic        neg;
    logic [63:0] p00;
    logic [63:0] p01;
    logic [63:0] p10;
    logic [63:0] p11;
  } pp_t;

  // first half of a Q60 product: magnitudes split into 32-bit halves
  function automatic pp_t qmul_pp(input logic signed [63:0] a,
                                  input logic signed [63:0] b);
    logic [63:0] ua;
    logic [63:0] ub;
    logic [31:0] a0;
    logic [31:0] a1;
    logic [31:0] b0;
    logic [31:0] b1;
    pp_t         pp;
    ua = a[63] ? 64'(-a) : 64'(a);
    ub = b[63] ? 64'(-b) : 64'(b);
    a0 = ua[31:0];
    a1 = ua[63:32];
    b0 = ub[31:0];
    b1 = ub[63:32];
    pp.neg = a[63] ^ b[63];
    pp.p00 = a0 * b0;
    pp.p01 = a0 * b1;
    pp.p10 = a1 * b0;
    pp.p11 = a1 * b1;
    return pp;
  endfunction

  // second half: sum, round half away from zero, keep 62 bits, apply sign
  function automatic logic signed [63:0] qmul_fin(input pp_t pp);
    logic [127:0] p;
    logic [63:0]  r;
    p = {pp.p11, pp.p00} + ({64'd0, pp.p01} << 32) + ({64'd0, pp.p10} << 32) +
        (128'd1 << (QF - 1));
    r = {2'b00, p[QF+61:QF]};
    return pp.neg ? -$signed(r) : $signed(r);
  endfunction

  // floor(sqrt(v)) in Q60, elaboration use only
  function automatic logic [63:0] sqrt_q(input logic [63:0] v);
    logic [63:0]  r;
    logic [63:0]  t;
    logic [127:0] t2;
    logic [127:0] vv;
    vv = {64'd0, v} << QF;
    r = '0;
    for (int b = QF; b >= 0; b--) begin
      t = r | (64'd1 << b);
      t2 = {64'd0, t} * {64'd0, t};
      if (t2 <= vv) r = t;
    end
    return r;
  endfunction

  // floor(n/d) in Q60 for n < d, elaboration use only
  function automatic logic [63:0] div_q(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] rem;
    logic [63:0] q;
    rem = n;
    q = '0;
    if (d == 64'd0 || n >= d) return 64'd0;
    for (int i = 0; i < QF; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= d) begin
        rem = rem - d;
        q = q | 64'd1;
      end
    end
    return q;
  endfunction

  // cos/sin of 2pi/2^k by repeated halving
  function automatic tab_t tab_entry(input int k);
    logic [63:0] c;
    logic [63:0] s;
    logic [63:0] cn;
    tab_t        t;
    c = '0;
    s = QONE;
    for (int i = 3; i <= k; i++) begin
      cn = sqrt_q((64'(QONE) + c) >> 1);
      s = div_q(s, cn << 1);
      c = cn;
    end
    t.c = $signed(c);
    t.s = $signed(s);
    return t;
  endfunction

  // starting vector of the sine/cosine chain: half and quarter turn applied
  function automatic fold_t sc_init(input logic [ANGLE_BITS-1:0] ang);
    fold_t f;
    f.x = ang[ANGLE_BITS-1] ? -QONE : QONE;
    f.y = '0;
    f.acc = ang;
    if (ang[ANGLE_BITS-2]) begin
      f.y = f.x;
      f.x = '0;
    end
    return f;
  endfunction

  // bring a vector into the first quadrant, noting the turns removed
  function automatic fold_t fold(input logic signed [63:0] x, input logic signed [63:0] y);
    fold_t f;
    f.x = x;
    f.y = y;
    f.acc = '0;
    if (y < 0 || (y == 0 && x < 0)) begin
      f.x = -x;
      f.y = -y;
      f.acc = HALF_TURN;
    end
    if (f.x <= 0 && f.y > 0) begin
      f.y = -f.x;
      f.x = y[63] ? -y : y;
      f.acc = f.acc + QUARTER_TURN;
    end
    return f;
  endfunction

endpackage

// File: rtl/core/e2h_if.sv
interface e2h_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [e2h_pkg::ANGLE_BITS-1:0]        hour_angle;
  logic signed [e2h_pkg::ANGLE_BITS-1:0] declination;
  modport source(output valid, hour_angle, declination, input ready);
  modport sink(input valid, hour_angle, declination, output ready);
endinterface

interface e2h_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [e2h_pkg::ANGLE_BITS-1:0] altitude;
  logic [e2h_pkg::ANGLE_BITS-1:0]        azimuth;
  logic                                 near_zenith;
  modport source(output valid, altitude, azimuth, near_zenith, input ready);
  modport sink(input valid, altitude, azimuth, near_zenith, output ready);
endinterface

// File: rtl/core/equatorial_to_horizontal_converter.sv
// Channel   Dir  Payload                                   Handshake
// in_ch     in   hour_angle[31:0], declination[31:0] (s)   valid/ready
// out_ch    out  altitude[31:0] (s), azimuth[31:0],        valid/ready
//                near_zenith
// cfg_*     in   cfg_index[1:0], cfg_wdata[31:0]           cfg_we, no wait
//
// One item per cycle while the output is not stalled, through the input
// register, the sine/cosine cell chain, the seven product stages (partial
// products, then sums), the root and angle cell chains and output register.
// A stalled output holds the whole pipeline; ready follows the output stage.
// Synchronous active-low reset clears valid bits and loads register defaults.
module equatorial_to_horizontal_converter (
  input  logic                                clk,
  input  logic                                rst_n,
  e2h_in_if.sink                              in_ch,
  e2h_out_if.source                           out_ch,
  input  logic                                cfg_we,
  input  logic [1:0]                          cfg_index,
  input  logic [e2h_pkg::TRIG_FRAC_BITS+1:0]  cfg_wdata
);

  localparam int AB = e2h_pkg::ANGLE_BITS;
  localparam int QF = e2h_pkg::QF;
  localparam int TF = e2h_pkg::TRIG_FRAC_BITS;

  logic en;

  // configuration registers
  logic signed [TF+1:0] lat_sin_r;
  logic [TF:0]          lat_cos_r;
  logic [TF:0]          zen_thr_r;
  logic signed [63:0]   slat, clat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lat_sin_r <= '0;
      lat_cos_r <= (TF+1)'(1) << TF;
      zen_thr_r <= (TF+1)'(1825361);
    end else if (cfg_we) begin
      case (cfg_index)
        e2h_pkg::CFG_LAT_SINE:   lat_sin_r <= $signed(cfg_wdata[TF+1:0]);
        e2h_pkg::CFG_LAT_COSINE: lat_cos_r <= cfg_wdata[TF:0];
        e2h_pkg::CFG_ZEN_THRESH: zen_thr_r <= cfg_wdata[TF:0];
        default: ;
      endcase
    end
  end

  assign slat = 64'(lat_sin_r) <<< (QF - TF);
  assign clat = $signed({{(63-TF-QF+TF){1'b0}}, lat_cos_r, {(QF-TF){1'b0}}});

  // input register
  logic          s0_v_r;
  logic [AB-1:0] s0_ha_r, s0_dec_r;

  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (en) begin
      s0_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_ha_r <= in_ch.hour_angle;
      s0_dec_r <= in_ch.declination;
    end
  end

  // sine/cosine chains for hour angle (a) and declination (b)
  e2h_pkg::rot_pl_t sca [0:e2h_pkg::N_SC];
  e2h_pkg::rot_pl_t scb [0:e2h_pkg::N_SC];
  e2h_pkg::fold_t   ia, ib;

  always_comb begin
    ia = e2h_pkg::sc_init(s0_ha_r);
    ib = e2h_pkg::sc_init(s0_dec_r);
    sca[0] = '{valid: s0_v_r, x: ia.x, y: ia.y, acc: ia.acc, side: '0};
    scb[0] = '{valid: s0_v_r, x: ib.x, y: ib.y, acc: ib.acc, side: '0};
  end

  for (genvar j = 0; j < e2h_pkg::N_SC; j++) begin : g_sc
    localparam e2h_pkg::tab_t T = e2h_pkg::tab_entry(j + 3);
    localparam logic [AB-1:0] W = AB'(1) << (AB - 3 - j);
    e2h_rot_cell u_a (.clk, .rst_n, .en, .trial(1'b0), .c(T.c), .s(T.s),
                      .weight(W), .i_pl(sca[j]), .o_pl(sca[j+1]));
    e2h_rot_cell u_b (.clk, .rst_n, .en, .trial(1'b0), .c(T.c), .s(T.s),
                      .weight(W), .i_pl(scb[j]), .o_pl(scb[j+1]));
  end

  // product stages: partial products in one stage, their sum in the next
  logic [7:1]         pv_r;
  e2h_pkg::pp_t       p1_a_r, p1_b_r, p3_a_r, p3_b_r, p5_a_r, p6_a_r, p6_b_r;
  logic signed [63:0] p1_cha_r, p1_sha_r, p1_cdec_r, p1_sdec_r;
  logic signed [63:0] p2_p1_r, p2_p2_r, p2_cha_r, p2_sha_r, p2_cdec_r, p2_sdec_r;
  logic signed [63:0] p3_p1_r, p3_sdec_r;
  logic signed [63:0] p4_p1_r, p4_p3_r, p4_q1_r, p4_sdec_r;
  logic signed [63:0] p5_sh_r, p5_sdec_r;
  logic signed [63:0] p6_yv_r, p6_sh_r, p6_sdec_r;
  logic signed [63:0] p7_sq_r, p7_xv_r, p7_sh_r, p7_yv_r;
  logic signed [63:0] sh_sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= '0;
    end else if (en) begin
      pv_r <= {pv_r[6:1], sca[e2h_pkg::N_SC].valid};
    end
  end

  assign sh_sum = p4_p1_r + p4_p3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p1_a_r <= e2h_pkg::qmul_pp(slat, scb[e2h_pkg::N_SC].y);
      p1_b_r <= e2h_pkg::qmul_pp(clat, scb[e2h_pkg::N_SC].x);
      p1_cha_r <= sca[e2h_pkg::N_SC].x;
      p1_sha_r <= sca[e2h_pkg::N_SC].y;
      p1_cdec_r <= scb[e2h_pkg::N_SC].x;
      p1_sdec_r <= scb[e2h_pkg::N_SC].y;
      p2_p1_r <= e2h_pkg::qmul_fin(p1_a_r);
      p2_p2_r <= e2h_pkg::qmul_fin(p1_b_r);
      p2_cha_r <= p1_cha_r;
      p2_sha_r <= p1_sha_r;
      p2_cdec_r <= p1_cdec_r;
      p2_sdec_r <= p1_sdec_r;
      p3_a_r <= e2h_pkg::qmul_pp(p2_p2_r, p2_cha_r);
      p3_b_r <= e2h_pkg::qmul_pp(p2_cdec_r, p2_sha_r);
      p3_p1_r <= p2_p1_r;
      p3_sdec_r <= p2_sdec_r;
      p4_p1_r <= p3_p1_r;
      p4_p3_r <= e2h_pkg::qmul_fin(p3_a_r);
      p4_q1_r <= e2h_pkg::qmul_fin(p3_b_r);
      p4_sdec_r <= p3_sdec_r;
      // saturate sin(alt) to [-1, 1]
      if (sh_sum > e2h_pkg::QONE) p5_sh_r <= e2h_pkg::QONE;
      else if (sh_sum < -e2h_pkg::QONE) p5_sh_r <= -e2h_pkg::QONE;
      else p5_sh_r <= sh_sum;
      p5_a_r <= e2h_pkg::qmul_pp(p4_q1_r, clat);
      p5_sdec_r <= p4_sdec_r;
      p6_a_r <= e2h_pkg::qmul_pp(p5_sh_r, p5_sh_r);
      p6_b_r <= e2h_pkg::qmul_pp(slat, p5_sh_r);
      p6_yv_r <= -e2h_pkg::qmul_fin(p5_a_r);
      p6_sh_r <= p5_sh_r;
      p6_sdec_r <= p5_sdec_r;
      p7_sq_r <= e2h_pkg::qmul_fin(p6_a_r);
      p7_xv_r <= p6_sdec_r - e2h_pkg::qmul_fin(p6_b_r);
      p7_sh_r <= p6_sh_r;
      p7_yv_r <= p6_yv_r;
    end
  end

  // square root chain for cos(alt); side: sh, xv, yv, radicand
  e2h_pkg::sq_pl_t    sqp [0:e2h_pkg::N_SQ];
  logic signed [63:0] vrad;

  always_comb begin
    vrad = e2h_pkg::QONE - p7_sq_r;
    if (vrad < 0) vrad = '0;
    sqp[0].valid = pv_r[7];
    sqp[0].rem = '0;
    sqp[0].root = '0;
    sqp[0].side = {vrad, p7_yv_r, p7_xv_r, p7_sh_r};
  end

  for (genvar j = 0; j < e2h_pkg::N_SQ; j++) begin : g_sq
    localparam int I = QF - j;
    logic [2*QF+1:0] nv;
    assign nv = {sqp[j].side[192 +: 62], {QF{1'b0}}};
    e2h_sqrt_cell u_sq (.clk, .rst_n, .en, .pair(nv[2*I+1 -: 2]),
                        .i_pl(sqp[j]), .o_pl(sqp[j+1]));
  end

  // zenith test and quadrant folding ahead of the angle chains
  e2h_pkg::rot_pl_t   ala [0:e2h_pkg::N_ANG];
  e2h_pkg::rot_pl_t   aza [0:e2h_pkg::N_ANG];
  logic signed [63:0] calt, q_sh, q_xv, q_yv, xv4, yv4;
  logic [63:0]        cq;
  logic               nz, az_zero, alt_zero;
  e2h_pkg::fold_t     fa, fz;

  always_comb begin
    calt = $signed({3'b000, sqp[e2h_pkg::N_SQ].root[60:0]});
    q_sh = sqp[e2h_pkg::N_SQ].side[63:0];
    q_xv = sqp[e2h_pkg::N_SQ].side[127:64];
    q_yv = sqp[e2h_pkg::N_SQ].side[191:128];
    cq = (64'(calt) + (64'd1 << (QF - TF - 1))) >> (QF - TF);
    nz = !(cq > {{(63-TF){1'b0}}, zen_thr_r});
    xv4 = q_xv / 64'sd4;
    yv4 = q_yv / 64'sd4;
    az_zero = (xv4 == 0) && (yv4 == 0);
    alt_zero = (calt == 0) && (q_sh == 0);
    fa = e2h_pkg::fold(calt, q_sh);
    fz = e2h_pkg::fold(xv4, yv4);
    ala[0] = '{valid: sqp[e2h_pkg::N_SQ].valid, x: fa.x, y: fa.y, acc: fa.acc,
               side: {{(e2h_pkg::SIDE_W-3){1'b0}}, alt_zero, az_zero, nz}};
    aza[0] = '{valid: sqp[e2h_pkg::N_SQ].valid, x: fz.x, y: fz.y, acc: fz.acc,
               side: '0};
  end

  for (genvar j = 0; j < e2h_pkg::N_ANG; j++) begin : g_ang
    localparam e2h_pkg::tab_t T = e2h_pkg::tab_entry(j + 3);
    localparam logic [AB-1:0] W = (j + 3 <= AB) ? (AB'(1) << (AB - 3 - j)) : AB'(1);
    e2h_rot_cell u_alt (.clk, .rst_n, .en, .trial(1'b1), .c(T.c), .s(T.s),
                        .weight(W), .i_pl(ala[j]), .o_pl(ala[j+1]));
    e2h_rot_cell u_az (.clk, .rst_n, .en, .trial(1'b1), .c(T.c), .s(T.s),
                       .weight(W), .i_pl(aza[j]), .o_pl(aza[j+1]));
  end

  // output register
  logic          out_v_r, out_nz_r;
  logic [AB-1:0] out_alt_r, out_az_r;
  logic [2:0]    fin_flags;

  assign en = !out_v_r || out_ch.ready;
  assign fin_flags = ala[e2h_pkg::N_ANG].side[2:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= ala[e2h_pkg::N_ANG].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_alt_r <= fin_flags[2] ? '0 : ala[e2h_pkg::N_ANG].acc;
      out_nz_r <= fin_flags[0];
      if (fin_flags[0]) out_az_r <= e2h_pkg::HALF_TURN;
      else if (fin_flags[1]) out_az_r <= '0;
      else out_az_r <= aza[e2h_pkg::N_ANG].acc;
    end
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.altitude = out_alt_r;
  assign out_ch.azimuth = out_az_r;
  assign out_ch.near_zenith = out_nz_r;

  // checks
  a_zen_half: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_nz_r |-> out_az_r == e2h_pkg::HALF_TURN)
    else $error("near zenith item without half-turn azimuth");

  a_alt_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> ($signed(out_alt_r) <= $signed(e2h_pkg::QUARTER_TURN)) &&
                ($signed(out_alt_r) >= -$signed(e2h_pkg::QUARTER_TURN)))
    else $error("altitude beyond a quarter turn");

  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_v_r)
    else $error("output valid after reset");

endmodule

// File: rtl/core/e2h_rot_cell.sv
// One rotation step: partial products are registered first, then either a
// conditional forward rotation selected by the angle bit in acc, or a trial
// backward rotation kept while y stays >= 0.
module e2h_rot_cell (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            trial,
  input  logic signed [63:0]              c,
  input  logic signed [63:0]              s,
  input  logic [e2h_pkg::ANGLE_BITS-1:0]  weight,
  input  e2h_pkg::rot_pl_t                i_pl,
  output e2h_pkg::rot_pl_t                o_pl
);

  e2h_pkg::pp_t       xc_nxt, ys_nxt, yc_nxt, xs_nxt;
  e2h_pkg::pp_t       xc_r, ys_r, yc_r, xs_r;
  e2h_pkg::rot_pl_t   mid_r;
  logic               mid_v_r;
  logic signed [63:0] xc, ys, yc, xs, fx, fy, bx, by;
  logic               do_rot;
  e2h_pkg::rot_pl_t   pl_nxt;
  e2h_pkg::rot_pl_t   pl_r;
  logic               valid_r;

  // partial products of the four terms
  always_comb begin
    xc_nxt = e2h_pkg::qmul_pp(i_pl.x, c);
    ys_nxt = e2h_pkg::qmul_pp(i_pl.y, s);
    yc_nxt = e2h_pkg::qmul_pp(i_pl.y, c);
    xs_nxt = e2h_pkg::qmul_pp(i_pl.x, s);
  end

  // products summed, shared by both directions
  always_comb begin
    xc = e2h_pkg::qmul_fin(xc_r);
    ys = e2h_pkg::qmul_fin(ys_r);
    yc = e2h_pkg::qmul_fin(yc_r);
    xs = e2h_pkg::qmul_fin(xs_r);
    fx = xc - ys;
    fy = yc + xs;
    bx = xc + ys;
    by = yc - xs;
  end

  always_comb begin
    pl_nxt = mid_r;
    do_rot = |(mid_r.acc & weight);
    if (trial) begin
      if (!by[63]) begin
        pl_nxt.x = bx;
        pl_nxt.y = by;
        pl_nxt.acc = mid_r.acc + weight;
      end
    end else if (do_rot) begin
      pl_nxt.x = fx;
      pl_nxt.y = fy;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_v_r <= 1'b0;
      valid_r <= 1'b0;
    end else if (en) begin
      mid_v_r <= i_pl.valid;
      valid_r <= mid_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mid_r <= i_pl;
      xc_r <= xc_nxt;
      ys_r <= ys_nxt;
      yc_r <= yc_nxt;
      xs_r <= xs_nxt;
      pl_r <= pl_nxt;
    end
  end

  always_comb begin
    o_pl = pl_r;
    o_pl.valid = valid_r;
  end

endmodule

// File: rtl/core/e2h_sqrt_cell.sv
// One result bit of a restoring square root, two radicand bits per step.
module e2h_sqrt_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic [1:0]       pair,
  input  e2h_pkg::sq_pl_t  i_pl,
  output e2h_pkg::sq_pl_t  o_pl
);

  logic [65:0]     remx;
  logic [65:0]     tri_v;
  e2h_pkg::sq_pl_t pl_nxt;
  e2h_pkg::sq_pl_t pl_r;
  logic            valid_r;

  always_comb begin
    pl_nxt = i_pl;
    remx = {i_pl.rem[63:0], pair};
    tri_v = {1'b0, i_pl.root, 2'b01};
    if (remx >= tri_v) begin
      pl_nxt.rem = remx - tri_v;
      pl_nxt.root = {i_pl.root[61:0], 1'b1};
    end else begin
      pl_nxt.rem = remx;
      pl_nxt.root = {i_pl.root[61:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= i_pl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pl_r <= pl_nxt;
    end
  end

  always_comb begin
    o_pl = pl_r;
    o_pl.valid = valid_r;
  end

endmodule
